// ===== sv/gb3_pkg.sv =====
// Package for the 3x3 RGB Gaussian blur: sizes, register indexes, pixel and
// column types, the result record and the blur arithmetic.
// No dependencies.
package gb3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);

    // Field widths of the two configuration registers.
    localparam int CFG_WIDTH_FIELD_W  = 12;
    localparam int CFG_HEIGHT_FIELD_W = 13;
    localparam int CFG_DATA_W         = 13;
    localparam int CFG_INDEX_W        = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(480);

    localparam int FIFO_DEPTH = 3;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_W      = CNT_W + 1;

    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0]  pix_t;

    // One window column, top row first.
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  last;
    } result_t;

    // Weighted sum of one channel; corners >> 4, edges >> 3, centre >> 2.
    // The largest possible sum is 247, so eight bits never overflow.
    function automatic chan_t blur_chan(input chan_t lt, input chan_t mt, input chan_t rt,
                                        input chan_t lm, input chan_t mm, input chan_t rm,
                                        input chan_t lb, input chan_t mb, input chan_t rb);
        chan_t corners;
        chan_t edges;
        corners = (lt >> 4) + (rt >> 4) + (lb >> 4) + (rb >> 4);
        edges   = (mt >> 3) + (lm >> 3) + (rm >> 3) + (mb >> 3);
        return corners + edges + (mm >> 2);
    endfunction

    function automatic chan_t blur_at(input col_t l, input col_t m, input col_t r,
                                      input int k);
        return blur_chan(l.top[k*CHAN_W +: CHAN_W], m.top[k*CHAN_W +: CHAN_W],
                         r.top[k*CHAN_W +: CHAN_W], l.mid[k*CHAN_W +: CHAN_W],
                         m.mid[k*CHAN_W +: CHAN_W], r.mid[k*CHAN_W +: CHAN_W],
                         l.bot[k*CHAN_W +: CHAN_W], m.bot[k*CHAN_W +: CHAN_W],
                         r.bot[k*CHAN_W +: CHAN_W]);
    endfunction

    // Red sits in the low byte of a pixel word, blue in the high byte.
    function automatic result_t blur_pixel(input col_t l, input col_t m, input col_t r,
                                           input logic last);
        result_t res;
        res.red   = blur_at(l, m, r, 0);
        res.green = blur_at(l, m, r, 1);
        res.blue  = blur_at(l, m, r, 2);
        res.last  = last;
        return res;
    endfunction

endpackage

// ===== sv/gb3_line_store.sv =====
// Two line memories holding the previous two image rows, one pixel per entry.
// Reads are registered; both memories share the read and write addresses.
// Depends on gb3_pkg.
module gb3_line_store (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [gb3_pkg::COL_W-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [gb3_pkg::COL_W-1:0] wr_addr,
    input  gb3_pkg::pix_t             wr_upper,
    input  gb3_pkg::pix_t             wr_middle,
    output gb3_pkg::pix_t             rd_upper,
    output gb3_pkg::pix_t             rd_middle
);
    import gb3_pkg::*;

    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];
    pix_t rd_upper_reg;
    pix_t rd_middle_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_upper_reg  <= upper_mem[rd_addr];
            rd_middle_reg <= middle_mem[rd_addr];
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;

endmodule

// ===== sv/gb3_out_fifo.sv =====
// Small result queue in front of the output channel; it lets the stage before
// it run on while the receiver stalls. Depends on gb3_pkg.
module gb3_out_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  gb3_pkg::result_t          push_data,
    input  logic                      pop,
    output logic                      head_valid,
    output gb3_pkg::result_t          head_data,
    output logic [gb3_pkg::CNT_W-1:0] count
);
    import gb3_pkg::*;

    result_t            entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_pop;

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/gaussian_blur_3x3_rgb.sv =====
// Streaming 3x3 Gaussian blur of an RGB frame, top level.
// Depends on gb3_pkg, gb3_line_store and gb3_out_fifo.
//
// Usage
//   Pixels enter in raster order on the input channel (in_valid/in_ready);
//   req_type = 0 marks an image pixel, req_type = 1 a drain tick. Drain ticks
//   inside the frame are accepted and dropped. After the W*H pixels of a frame
//   the source sends W + 1 further transfers of any kind: the first W stand
//   in for the zero border below and to the right, and the last one releases
//   the frame's final result, flagged by frame_last, after which a new frame
//   starts. Blurred pixels leave in raster order on the output channel
//   (out_valid/out_ready), lagging the input by W + 1 positions.
//   The block takes one transfer per clock cycle while in_ready is high. The line
//   memory read and the blur adders share one stage: a result enters the output
//   queue at the edge after the input transfer that causes it, and out_valid
//   rises once the queue holds it.
//   A three-entry output queue absorbs stalls of the receiver; in_ready falls
//   only when the queue together with the item in the blur stage could fill it.
//   Reset sets the width to 640 and the height to 480 and restarts the frame;
//   the line memories are not cleared, since a row is never used before it is
//   written. A configuration write restarts the frame and must only be issued
//   while the block is idle.
module gaussian_blur_3x3_rgb (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [7:0]                     red_in,
    input  logic [7:0]                     green_in,
    input  logic [7:0]                     blue_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     red_out,
    output logic [7:0]                     green_out,
    output logic [7:0]                     blue_out,
    output logic                           frame_last
);
    import gb3_pkg::*;

    // Control word of the item in the blur stage.
    typedef struct packed {
        logic             final_op;
        logic             col_zero;
        logic             row_ge1;
        logic             row_ge2;
        logic             emit;
        logic [COL_W-1:0] idx;
        pix_t             cur;
    } stage_t;

    // Configuration registers.
    logic [WIDTH_W-1:0]  width_reg;
    logic [WIDTH_W-1:0]  width_next;
    logic [HEIGHT_W-1:0] height_reg;
    logic [HEIGHT_W-1:0] height_next;

    // Stream position.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    // Blur stage.
    logic   s1_valid_reg;
    stage_t s1_reg;
    stage_t s1_next;

    // Forwarding of the line write that happens at the same edge as a read.
    logic fwd_hit_reg;
    pix_t fwd_upper_reg;
    pix_t fwd_middle_reg;

    // Window: the two older columns.
    col_t win_old_reg;
    col_t win_old_next;
    col_t win_new_reg;
    col_t win_new_next;

    logic                       accept;
    logic                       in_frame;
    logic                       drain_skip;
    logic                       is_final;
    logic                       pixel_op;
    logic [WIDTH_W-1:0]         col_inc;
    logic [ROW_W-1:0]           height_ext;
    logic [CFG_WIDTH_FIELD_W-1:0]  cfg_w_field;
    logic [CFG_HEIGHT_FIELD_W-1:0] cfg_h_field;

    pix_t    mem_rd_upper;
    pix_t    mem_rd_middle;
    pix_t    upper_rd;
    pix_t    middle_rd;
    col_t    new_col;
    col_t    right_col;
    logic    push;
    result_t push_data;
    result_t head_data;
    logic    head_valid;
    logic [CNT_W-1:0] fifo_count;
    logic [OCC_W-1:0] occupancy;

    // ------------------------------------------------------------------
    // Configuration: zero means one, anything above the maximum saturates.
    // ------------------------------------------------------------------
    assign cfg_w_field = cfg_data[CFG_WIDTH_FIELD_W-1:0];
    assign cfg_h_field = cfg_data[CFG_HEIGHT_FIELD_W-1:0];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_w_field == '0)
                        width_next = WIDTH_W'(1);
                    else if (CFG_WIDTH_FIELD_W'(MAX_WIDTH) < cfg_w_field)
                        width_next = WIDTH_W'(MAX_WIDTH);
                    else
                        width_next = WIDTH_W'(cfg_w_field);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_h_field == '0)
                        height_next = HEIGHT_W'(1);
                    else if (CFG_HEIGHT_FIELD_W'(MAX_HEIGHT) < cfg_h_field)
                        height_next = HEIGHT_W'(MAX_HEIGHT);
                    else
                        height_next = HEIGHT_W'(cfg_h_field);
                end
                default:
                begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // ------------------------------------------------------------------
    // Input side: classify the transfer against the current position.
    // ------------------------------------------------------------------
    assign occupancy = OCC_W'(fifo_count) + OCC_W'(s1_valid_reg);
    assign in_ready  = (occupancy <= OCC_W'(FIFO_DEPTH - 1));
    assign accept    = in_valid && in_ready;

    assign height_ext = ROW_W'(height_reg);
    assign in_frame   = (row_reg < height_ext);
    assign drain_skip = in_frame && req_type;
    assign is_final   = (height_ext < row_reg);
    assign pixel_op   = !drain_skip && !is_final;
    assign col_inc    = WIDTH_W'(col_reg) + WIDTH_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept && is_final)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept && pixel_op)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_next.final_op = is_final;
        s1_next.col_zero = (col_reg == '0);
        s1_next.row_ge1  = (row_reg >= ROW_W'(1));
        s1_next.row_ge2  = (row_reg >= ROW_W'(2));
        s1_next.idx      = col_reg;
        // Rows below the frame feed zeros into the window.
        s1_next.cur      = in_frame ? {blue_in, green_in, red_in} : '0;
        if (is_final)
            s1_next.emit = 1'b1;
        else if (col_reg == '0)
            s1_next.emit = (row_reg >= ROW_W'(2));
        else
            s1_next.emit = (row_reg >= ROW_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_reg       <= '0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept && !drain_skip;
            if (accept)
            begin
                s1_reg <= s1_next;
            end
            // The item in the blur stage writes the same entry at this edge.
            fwd_hit_reg <= accept && s1_valid_reg && !s1_reg.final_op
                           && (s1_reg.idx == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_upper_reg  <= middle_rd;
        fwd_middle_reg <= s1_reg.cur;
    end

    // ------------------------------------------------------------------
    // Line memories.
    // ------------------------------------------------------------------
    gb3_line_store u_lines (
        .clk       (clk),
        .rd_en     (accept && pixel_op),
        .rd_addr   (col_reg),
        .wr_en     (s1_valid_reg && !s1_reg.final_op),
        .wr_addr   (s1_reg.idx),
        .wr_upper  (middle_rd),
        .wr_middle (s1_reg.cur),
        .rd_upper  (mem_rd_upper),
        .rd_middle (mem_rd_middle)
    );

    // ------------------------------------------------------------------
    // Blur stage: build the new column, blur, shift the window.
    // ------------------------------------------------------------------
    assign upper_rd  = fwd_hit_reg ? fwd_upper_reg  : mem_rd_upper;
    assign middle_rd = fwd_hit_reg ? fwd_middle_reg : mem_rd_middle;

    always_comb
    begin
        // Rows above the frame are zero border, whatever the memory holds.
        new_col.top = s1_reg.row_ge2 ? upper_rd  : '0;
        new_col.mid = s1_reg.row_ge1 ? middle_rd : '0;
        new_col.bot = s1_reg.cur;
        // The right-hand column is border at a row end and for the final pixel.
        if (s1_reg.final_op || s1_reg.col_zero)
            right_col = '0;
        else
            right_col = new_col;
    end

    assign push      = s1_valid_reg && s1_reg.emit;
    assign push_data = blur_pixel(win_old_reg, win_new_reg, right_col, s1_reg.final_op);

    always_comb
    begin
        win_old_next = win_old_reg;
        win_new_next = win_new_reg;
        if (cfg_we)
        begin
            win_old_next = '0;
            win_new_next = '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_reg.final_op)
            begin
                win_old_next = '0;
                win_new_next = '0;
            end
            else
            begin
                win_old_next = s1_reg.col_zero ? '0 : win_new_reg;
                win_new_next = new_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_old_reg <= '0;
            win_new_reg <= '0;
        end
        else
        begin
            win_old_reg <= win_old_next;
            win_new_reg <= win_new_next;
        end
    end

    // ------------------------------------------------------------------
    // Output queue.
    // ------------------------------------------------------------------
    gb3_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (out_ready),
        .head_valid (head_valid),
        .head_data  (head_data),
        .count      (fifo_count)
    );

    assign out_valid  = head_valid;
    assign red_out    = head_data.red;
    assign green_out  = head_data.green;
    assign blue_out   = head_data.blue;
    assign frame_last = head_data.last;

endmodule

// ===== sv/gb3_checker.sv =====
// Port-level checks for the 3x3 RGB Gaussian blur, bound to the top level.
// Depends on gaussian_blur_3x3_rgb's port list only.
module gb3_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out,
    input logic       frame_last
);

    // A waiting result is not withdrawn while the receiver stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transfer withdrawn during stall");

    // Its payload holds as well.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red_out) && $stable(green_out)
                                    && $stable(blue_out) && $stable(frame_last))
        else $error("output payload changed during stall");

    // The shifts truncate each kernel term, so no channel exceeds 247.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_out <= 8'd247) && (green_out <= 8'd247)
                      && (blue_out <= 8'd247))
        else $error("blurred channel out of range");

    // With nothing queued the block always takes input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output queue");

endmodule

bind gaussian_blur_3x3_rgb gb3_checker u_gb3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .frame_last (frame_last)
);
